// File: hw/rtl/prcc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prcc_pkg
// Shared types, constants and helpers for the packet reassembly CRC checker.
// ---------------------------------------------------------------------------
package prcc_pkg;

  // Largest file limit honored, whatever the capacity register holds
  localparam int unsigned FILE_BYTES_MAX = 4096;
  // Largest payload of one packet; packets longer than PAYLOAD_MAX + 4 bytes are treated as faulty
  localparam int unsigned PAYLOAD_MAX    = 250;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int unsigned CAP_W      = 13;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic REG_FILE_CAPACITY = 1'b0;

  // Result status codes
  typedef enum logic [2:0] {
    ST_RADIO_ERR = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_TAKEN     = 3'd2,
    ST_FILE_OK   = 3'd3,
    ST_CRC_BAD   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] packet_len;
    logic       radio_error;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       packet_index;
    logic [7:0]       packet_total;
    logic [15:0]      computed_crc;
    logic [15:0]      expected_crc;
    logic [CAP_W-1:0] file_bytes;
    logic             payload_dropped;
  } out_item_t;

  // Payload bytes after the header: 4-byte header on index 0, else 2
  function automatic logic [7:0] payload_size(input logic [7:0] idx,
                                              input logic [7:0] len);
    logic [7:0] hdr;
    hdr = (idx == 8'd0) ? 8'd4 : 8'd2;
    return (len >= hdr) ? (len - hdr) : 8'd0;
  endfunction

endpackage

// File: hw/rtl/prcc_crc_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prcc_crc_update
// One-byte CRC-16 update, polynomial 0x1021, MSB first, unrolled.
// ---------------------------------------------------------------------------
module prcc_crc_update
  import prcc_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  // Eight shift/xor steps on a 16-bit value
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// File: hw/rtl/prcc_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prcc_cfg_regs
// APB-style register file holding the file capacity, with the clamped limit.
// ---------------------------------------------------------------------------
module prcc_cfg_regs
  import prcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CAP_W-1:0]      cap_limit
);

  logic [CAP_W-1:0] capacity_r;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (wr_en && (reg_sel == REG_FILE_CAPACITY)) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  // Read decode
  always_comb begin
    unique case (reg_sel)
      REG_FILE_CAPACITY: prdata = {{(CFG_DATA_W-CAP_W){1'b0}}, capacity_r};
      default:           prdata = '0;
    endcase
  end

  // Effective limit: min(capacity, FILE_BYTES_MAX)
  assign cap_limit = (32'(capacity_r) > 32'(FILE_BYTES_MAX))
                     ? CAP_W'(FILE_BYTES_MAX) : capacity_r;

endmodule

// File: hw/rtl/prcc_track.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prcc_track
// Packet position tracking, header capture, running file CRC and status.
// ---------------------------------------------------------------------------
module prcc_track
  import prcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  in_item_t         item,
  input  logic [CAP_W-1:0] cap_limit,
  output logic             res_valid,
  output out_item_t        res
);

  localparam logic [8:0] FAULT_LEN = 9'(PAYLOAD_MAX + 4);

  logic [7:0]       byte_pos_r,  byte_pos_nxt;
  logic [7:0]       index_r,     index_nxt;
  logic [7:0]       total_r,     total_nxt;
  logic [7:0]       hold_r,      hold_nxt;
  logic             take_r,      take_nxt;
  logic             fault_r,     fault_nxt;
  logic [CAP_W-1:0] acc_r,       acc_nxt;
  logic [15:0]      crc_r,       crc_nxt;
  logic [15:0]      hdr_crc_r,   hdr_crc_nxt;

  logic [15:0]      crc_upd;
  logic [CAP_W-1:0] acc_base;
  logic [7:0]       pl_size;
  logic [7:0]       len;
  logic [7:0]       data;
  logic             len_ok;
  logic             last_byte;

  assign len    = item.packet_len;
  assign data   = item.data_byte;
  assign len_ok = (len >= 8'd2);

  prcc_crc_update u_crc (
    .crc_in  (crc_r),
    .data_in (data),
    .crc_out (crc_upd)
  );

  // Next state for one item
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    index_nxt    = index_r;
    total_nxt    = total_r;
    hold_nxt     = hold_r;
    take_nxt     = take_r;
    fault_nxt    = fault_r;
    acc_nxt      = acc_r;
    crc_nxt      = crc_r;
    hdr_crc_nxt  = hdr_crc_r;
    acc_base     = acc_r;
    pl_size      = payload_size(data, len);
    last_byte    = ({1'b0, byte_pos_r} + 9'd1) >= {1'b0, len};

    if (len != 8'd0) begin
      if (byte_pos_r == 8'd0) begin
        // Header byte 0: sample the fault, capture index, maybe restart file
        fault_nxt = item.radio_error || ({1'b0, len} > FAULT_LEN);
        take_nxt  = 1'b0;
        if (!fault_nxt && len_ok) begin
          index_nxt = data;
          if (data == 8'd0) begin
            acc_base = '0;
            acc_nxt  = '0;
            crc_nxt  = CRC_INIT;
          end
          take_nxt = (pl_size != 8'd0) &&
                     (({1'b0, acc_base} + (CAP_W+1)'(pl_size)) <= {1'b0, cap_limit});
        end
      end else if (!fault_r && len_ok) begin
        if (byte_pos_r == 8'd1) begin
          total_nxt = data;
        end else if (index_r == 8'd0 && byte_pos_r == 8'd2) begin
          hold_nxt = data;
        end else if (index_r == 8'd0 && byte_pos_r == 8'd3) begin
          hdr_crc_nxt = {hold_r, data};
        end else if (take_r && (acc_r < cap_limit)) begin
          crc_nxt = crc_upd;
          acc_nxt = acc_r + CAP_W'(1);
        end
      end
      byte_pos_nxt = last_byte ? 8'd0 : (byte_pos_r + 8'd1);
    end else begin
      byte_pos_nxt = 8'd0;
    end
  end

  // Status on the last byte of a packet
  always_comb begin
    res_valid           = (len != 8'd0) && last_byte;
    res.status          = ST_TAKEN;
    res.packet_index    = 8'd0;
    res.packet_total    = 8'd0;
    res.computed_crc    = crc_nxt;
    res.expected_crc    = hdr_crc_nxt;
    res.file_bytes      = acc_nxt;
    res.payload_dropped = 1'b0;
    if (fault_nxt) begin
      res.status = ST_RADIO_ERR;
    end else if (!len_ok) begin
      res.status = ST_TOO_SHORT;
    end else begin
      res.packet_index    = index_nxt;
      res.packet_total    = total_nxt;
      res.payload_dropped = !take_nxt && (payload_size(index_nxt, len) != 8'd0);
      if (total_nxt != 8'd0 && index_nxt == (total_nxt - 8'd1)) begin
        res.status = (crc_nxt == hdr_crc_nxt) ? ST_FILE_OK : ST_CRC_BAD;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      index_r    <= '0;
      total_r    <= '0;
      hold_r     <= '0;
      take_r     <= 1'b0;
      fault_r    <= 1'b0;
      acc_r      <= '0;
      crc_r      <= CRC_INIT;
      hdr_crc_r  <= '0;
    end else if (step) begin
      byte_pos_r <= byte_pos_nxt;
      index_r    <= index_nxt;
      total_r    <= total_nxt;
      hold_r     <= hold_nxt;
      take_r     <= take_nxt;
      fault_r    <= fault_nxt;
      acc_r      <= acc_nxt;
      crc_r      <= crc_nxt;
      hdr_crc_r  <= hdr_crc_nxt;
    end
  end

  // File state only moves when an item is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(crc_r) && $stable(acc_r) && $stable(byte_pos_r))
    else $error("file state changed without an item");

  // Mid-packet items advance the position by one
  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step && !res_valid && (len != 8'd0) |=> byte_pos_r == $past(byte_pos_r) + 8'd1)
    else $error("byte position did not advance");

  // A completed packet restarts position counting
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid |=> byte_pos_r == 8'd0)
    else $error("byte position not cleared at packet end");

endmodule

// File: hw/rtl/packet_reassembly_crc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packet_reassembly_crc_checker
// Reassembles radio packets byte by byte, checks the file CRC-16 on the fly.
//
//   Channel  Ports                          Moves
//   in       in_valid/in_ready/in_data      one received byte with length/error
//   out      out_valid/out_ready/out_data   one status item per finished packet
//   cfg      psel/penable/pwrite/paddr/...  file capacity register at 0x0
//
// One item per cycle while the status output is not stalled; an accepted byte goes
// through the input register, then the CRC/status logic, into the result register.
// The single-byte CRC update plus the final CRC compare set the cycle path.
// Synchronous active-low reset clears the file state and the capacity to 4096.
// A stalled result holds the pipeline; input keeps flowing into the input
// register while the result register is free or being emptied.
// ---------------------------------------------------------------------------
module packet_reassembly_crc_checker
  import prcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Byte input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // Status output
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic             s1_valid_r, s1_valid_nxt;
  in_item_t         s1_item_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  logic             adv;
  logic             in_take;
  logic             res_valid;
  out_item_t        res;
  logic [CAP_W-1:0] cap_limit;

  prcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cap_limit (cap_limit)
  );

  // Stage 1 item advances when the result register can take a result
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_take  = in_valid && in_ready;

  prcc_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .item      (s1_item_r),
    .cap_limit (cap_limit),
    .res_valid (res_valid),
    .res       (res)
  );

  // Valid bookkeeping
  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    if (adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (adv && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new result only comes from an item held in the input register
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a pending item");

  // A held input item is not lost while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled input item dropped or changed");

endmodule

// File: dv/prcc_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prcc_result_checker
// Watches the byte, status and register channels of the reassembly block,
// keeps its own copy of the packet and file state, predicts the status item
// of every finished packet and compares each one field by field.
// ---------------------------------------------------------------------------
package prcc_tb_pkg;
  import prcc_pkg::*;

  // Byte address of the capacity register
  localparam logic [CFG_ADDR_W-1:0] CAP_ADDR = CFG_ADDR_W'(4 * REG_FILE_CAPACITY);

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] ccitt_crc_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction
endpackage

module prcc_result_checker
  import prcc_pkg::*;
  import prcc_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    outstanding
);

  // Shadow of the block's packet and file state
  logic [CAP_W-1:0] capacity;
  logic [7:0]       pos_q;
  logic [7:0]       index_q;
  logic [7:0]       total_q;
  logic [7:0]       crc_high_q;
  logic             take_q;
  logic             fault_q;
  logic [CAP_W-1:0] file_bytes_q;
  logic [15:0]      file_crc_q;
  logic [15:0]      header_crc_q;

  out_item_t expected_status_q[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic logic [CAP_W-1:0] capacity_limit();
    return (capacity > FILE_BYTES_MAX) ? CAP_W'(FILE_BYTES_MAX) : capacity;
  endfunction

  // Payload length after the 4-byte (index 0) or 2-byte header
  function automatic logic [7:0] body_len(input logic [7:0] idx, input logic [7:0] len);
    logic [7:0] hdr;
    hdr = (idx == 8'd0) ? 8'd4 : 8'd2;
    return (len >= hdr) ? len - hdr : 8'd0;
  endfunction

  function automatic void note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      note_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    end
  endfunction

  // Advance the shadow state by one byte; queue a status item at packet end
  function automatic void advance_reassembly(input in_item_t it);
    logic [7:0] pos;
    logic [7:0] body;
    out_item_t  rep;
    pos = pos_q;
    if (it.packet_len == 8'd0) begin
      pos_q = 8'd0;
      return;
    end

    if (pos == 8'd0) begin
      // error and size are sampled on the first byte only
      fault_q = it.radio_error || (it.packet_len > PAYLOAD_MAX + 4);
      take_q  = 1'b0;
      if (!fault_q && it.packet_len >= 8'd2) begin
        index_q = it.data_byte;
        if (it.data_byte == 8'd0) begin
          file_bytes_q = '0;
          file_crc_q   = CRC_INIT;
        end
        body   = body_len(it.data_byte, it.packet_len);
        take_q = (body != 8'd0) &&
                 (int'(file_bytes_q) + int'(body) <= int'(capacity_limit()));
      end
    end else if (!fault_q && it.packet_len >= 8'd2) begin
      if (pos == 8'd1) begin
        total_q = it.data_byte;
      end else if (index_q == 8'd0 && pos == 8'd2) begin
        crc_high_q = it.data_byte;
      end else if (index_q == 8'd0 && pos == 8'd3) begin
        header_crc_q = {crc_high_q, it.data_byte};
      end else if (take_q && file_bytes_q < capacity_limit()) begin
        file_crc_q   = ccitt_crc_byte(file_crc_q, it.data_byte);
        file_bytes_q = file_bytes_q + 1'b1;
      end
    end

    if (int'(pos) + 1 < int'(it.packet_len)) begin
      pos_q = pos + 8'd1;
      return;
    end
    pos_q = 8'd0;

    rep              = '0;
    rep.computed_crc = file_crc_q;
    rep.expected_crc = header_crc_q;
    rep.file_bytes   = file_bytes_q;
    if (fault_q) begin
      rep.status = ST_RADIO_ERR;
    end else if (it.packet_len < 8'd2) begin
      rep.status = ST_TOO_SHORT;
    end else begin
      rep.packet_index    = index_q;
      rep.packet_total    = total_q;
      rep.payload_dropped = !take_q && (body_len(index_q, it.packet_len) != 8'd0);
      if (total_q != 8'd0 && index_q == total_q - 8'd1) begin
        rep.status = (file_crc_q == header_crc_q) ? ST_FILE_OK : ST_CRC_BAD;
      end else begin
        rep.status = ST_TAKEN;
      end
    end
    expected_status_q.push_back(rep);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      capacity     = CAP_RESET;
      pos_q        = '0;
      index_q      = '0;
      total_q      = '0;
      crc_high_q   = '0;
      take_q       = 1'b0;
      fault_q      = 1'b0;
      file_bytes_q = '0;
      file_crc_q   = CRC_INIT;
      header_crc_q = '0;
      expected_status_q.delete();
    end else begin
      // results first, so an item cannot match a prediction made this edge
      if (out_valid && out_ready) begin
        if (expected_status_q.size() == 0) begin
          note_mismatch($sformatf("status item with none expected: status %0d index %0d",
                                  out_data.status, out_data.packet_index));
        end else begin
          want = expected_status_q.pop_front();
          compare_field("status",          16'(want.status),          16'(out_data.status));
          compare_field("packet_index",    16'(want.packet_index),    16'(out_data.packet_index));
          compare_field("packet_total",    16'(want.packet_total),    16'(out_data.packet_total));
          compare_field("computed_crc",    want.computed_crc,         out_data.computed_crc);
          compare_field("expected_crc",    want.expected_crc,         out_data.expected_crc);
          compare_field("file_bytes",      16'(want.file_bytes),      16'(out_data.file_bytes));
          compare_field("payload_dropped", 16'(want.payload_dropped), 16'(out_data.payload_dropped));
        end
      end

      if (in_valid && in_ready) advance_reassembly(in_data);

      // register port
      if (psel && penable && pready && paddr == CAP_ADDR) begin
        if (pwrite) begin
          capacity = pwdata[CAP_W-1:0];
        end else begin
          compare_field("file_capacity readback", 16'(capacity), prdata[15:0]);
          compare_field("readback upper bits", 16'd0, prdata[31:16]);
        end
      end
    end
    outstanding <= expected_status_q.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives received-packet bytes, status backpressure and capacity writes into
// the reassembly block; the checker beside it predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;
  import prcc_pkg::*;
  import prcc_tb_pkg::*;

  localparam int PHASE_ITEMS = 165;
  localparam int DRAIN_LIMIT = 20000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {
    NZ_RANDOM, NZ_SHORT, NZ_ZERO_LEN, NZ_LEN_CHANGE, NZ_NO_CRC, NZ_ZERO_TOTAL
  } noise_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int outstanding;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  logic [7:0] pkt_bytes[$];

  always #10 clk = ~clk;

  packet_reassembly_crc_checker i_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  prcc_result_checker i_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .outstanding
  );

  // Status backpressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic set_idling(input idle_mode_t m);
    send_idle_pct  = (m == IDLE_SENDER)   ? 68 : (m == IDLE_BOTH) ? 15 : 0;
    recv_stall_pct = (m == IDLE_RECEIVER) ? 68 : (m == IDLE_BOTH) ? 15 : 0;
  endtask

  task automatic send_byte(input logic [7:0] d, input logic [7:0] len, input logic err);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: d, packet_len: len, radio_error: err};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Error flag only matters on byte 0; later bytes get random noise on it
  task automatic send_packet(input int len, input logic err);
    for (int i = 0; i < len; i++) begin
      send_byte(pkt_bytes[i], 8'(len), (i == 0) ? err : ($urandom_range(9) == 0));
    end
  endtask

  task automatic fill_random(input int n);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endtask

  // One file: packets 0..total-1, header CRC over all payload (or corrupted)
  task automatic send_file(input int total, input bit crc_good);
    int          lens[$];
    logic [7:0]  body[$];
    logic [15:0] crc;
    logic [7:0]  b;
    int          hdr;
    int          pl;
    int          n;
    crc = CRC_INIT;
    for (int k = 0; k < total; k++) begin
      hdr = (k == 0) ? 4 : 2;
      pl  = ($urandom_range(9) == 0) ? $urandom_range(0, 254 - hdr) : $urandom_range(0, 20);
      lens.push_back(hdr + pl);
      repeat (pl) begin
        b = 8'($urandom);
        body.push_back(b);
        crc = ccitt_crc_byte(crc, b);
      end
    end
    if (!crc_good) crc ^= 16'h0001 << $urandom_range(15);
    n = 0;
    for (int k = 0; k < total; k++) begin
      pkt_bytes.delete();
      pkt_bytes.push_back(8'(k));
      pkt_bytes.push_back(8'(total));
      if (k == 0) begin
        pkt_bytes.push_back(crc[15:8]);
        pkt_bytes.push_back(crc[7:0]);
      end
      while (pkt_bytes.size() < lens[k]) begin
        pkt_bytes.push_back(body[n]);
        n++;
      end
      send_packet(lens[k], $urandom_range(19) == 0);
    end
  endtask

  // Broken and odd packets
  task automatic send_noise();
    noise_t kind;
    int     len;
    kind = noise_t'($urandom_range(NZ_ZERO_TOTAL));
    pkt_bytes.delete();
    case (kind)
      NZ_RANDOM: begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
        fill_random(len);
        send_packet(len, $urandom_range(1));
      end
      NZ_SHORT: begin
        fill_random(1);
        send_packet(1, $urandom_range(1));
      end
      NZ_ZERO_LEN: send_byte(8'($urandom), 8'd0, $urandom_range(1));
      NZ_LEN_CHANGE: begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom), 8'($urandom_range(1, 8)), $urandom_range(1));
        end
        // resync the byte position
        send_byte(8'($urandom), 8'd0, 1'b0);
      end
      NZ_NO_CRC: begin
        len = $urandom_range(2, 3);
        pkt_bytes.push_back(8'd0);
        pkt_bytes.push_back(($urandom_range(1) == 0) ? 8'd1 : 8'($urandom));
        fill_random(1);
        send_packet(len, 1'b0);
      end
      NZ_ZERO_TOTAL: begin
        len = $urandom_range(2, 10);
        pkt_bytes.push_back(($urandom_range(1) == 0) ? 8'd0 : 8'($urandom));
        pkt_bytes.push_back(8'd0);
        fill_random(len);
        send_packet(len, 1'b0);
      end
      default: ;
    endcase
  endtask

  // Setup and access phases, then idle with psel low before the next transfer
  task automatic cfg_access(input logic wr, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CAP_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (outstanding != 0 && guard < DRAIN_LIMIT);
    // pipeline may still hold bytes of an unfinished packet
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [15:0]           crc;
    logic [CFG_DATA_W-1:0] caps[6];
    int                    phase_start;
    caps = '{32'd4096, 32'd8191, 32'd0, 32'd60, 32'd4096, 32'($urandom_range(0, 8191))};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, '0);

    // Directed: short, zero length, radio error, oversize with length change,
    // good one-packet file, file restart without CRC, zero total, extreme bytes
    set_idling(IDLE_NONE);
    pkt_bytes = '{8'h00};
    send_packet(1, 1'b0);
    send_byte(8'hFF, 8'd0, 1'b1);
    pkt_bytes = '{8'hFF, 8'hFF};
    send_packet(2, 1'b1);
    send_byte(8'h00, 8'd255, 1'b0);
    send_byte(8'h12, 8'd2, 1'b0);
    crc = ccitt_crc_byte(ccitt_crc_byte(CRC_INIT, 8'h00), 8'hFF);
    pkt_bytes = '{8'h00, 8'h01, crc[15:8], crc[7:0], 8'h00, 8'hFF};
    send_packet(6, 1'b0);
    pkt_bytes = '{8'h00, 8'h01};
    send_packet(2, 1'b0);
    pkt_bytes = '{8'h05, 8'h00};
    send_packet(2, 1'b0);
    pkt_bytes = '{8'hFF, 8'h00, 8'hFF};
    send_packet(3, 1'b0);

    // Random phases, each with an idling mix; phases after the first write a capacity
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        cfg_access(1'b1, caps[ph]);
        cfg_access(1'b0, '0);
      end
      set_idling(idle_mode_t'(ph % 4));
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 75) begin
          send_file(($urandom_range(7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4),
                    $urandom_range(9) != 0);
        end else begin
          send_noise();
        end
      end
    end

    wait_drained();
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/prcc_pkg.sv
hw/rtl/prcc_crc_update.sv
hw/rtl/prcc_cfg_regs.sv
hw/rtl/prcc_track.sv
hw/rtl/packet_reassembly_crc_checker.sv
dv/prcc_result_checker.sv
dv/tb_top.sv
